// File: sv/mrbg_pkg.sv
// ----------------------------------------------------------------------------
// mrbg_pkg
// shared sizes, stack entry type and control structs for the rectangle block
// ----------------------------------------------------------------------------
package mrbg_pkg;

   localparam int MAX_COLUMNS = 256;
   localparam int MAX_ROWS    = 256;

   localparam int COL_W   = $clog2(MAX_COLUMNS);      // column index
   localparam int HGT_W   = $clog2(MAX_ROWS + 1);     // column height
   localparam int DEPTH_W = $clog2(MAX_COLUMNS + 1);  // stack depth and widths
   localparam int CNT_W   = 9;                        // column_count register
   localparam int AREA_W  = 17;
   localparam int PROD_W  = HGT_W + DEPTH_W;

   localparam logic [AREA_W-1:0] AREA_CAP = {AREA_W{1'b1}};
   localparam logic [CNT_W-1:0]  COLUMN_COUNT_RESET = CNT_W'(MAX_COLUMNS);

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;

   // stack entry: bar height and the left edge of the span it covers
   typedef struct packed {
      logic [HGT_W-1:0] height;
      logic [COL_W-1:0] left;
   } stk_entry_type;

   typedef struct packed {
      logic          clear;
      logic          pop;
      logic          push;
      stk_entry_type entry;
   } stk_cmd_type;

   typedef struct packed {
      logic          nonempty;
      stk_entry_type top;
   } stk_view_type;

endpackage

// File: sv/maximal_rectangle_binary_grid.sv
// ----------------------------------------------------------------------------
// maximal_rectangle_binary_grid
// largest all-ones rectangle of a binary grid streamed in row-major order
// ----------------------------------------------------------------------------
// Cells arrive one per request in row-major order, req_tdata[0] the cell value
// and req_tlast marking the final cell of the grid. Each column keeps a running
// height in a 256-entry memory (cleared, saturating at 256); each row's
// histogram is scanned with a monotonic stack whose top lives in registers and
// whose body lives in a second memory. A cell is accepted and its column
// height read; then the stack pops bars at least as tall, one at a time, and
// finally pushes the column. Since every column is pushed once, the pops
// average at most one per cell. A row end then pops each entry left on the
// stack, and a last cell then hands the grid area to an output register,
// where it sits while the next grid's cells are already taken. The last cell
// only completes once the previous result has been taken. Heights are cleared
// at once through per-column valid bits, so no clearing pass exists.
// csr_wr_data sets the row length: 0 means one column, above 256 means 256;
// lowering it mid-row ends the row at the current cell.
// ----------------------------------------------------------------------------
module maximal_rectangle_binary_grid (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mrbg_pkg::REQ_DATA_W-1:0] req_tdata,   // [0] cell_req, rest zero
   input  logic                            req_tlast,   // last_cell
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mrbg_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [16:0] max_area, rest zero
   // configuration
   input  logic                            csr_wr_en,
   input  logic [mrbg_pkg::CNT_W-1:0]      csr_wr_data  // column_count
);
   import mrbg_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for a cell
   localparam logic [1:0] ST_PROC  = 2'd1;  // pop bars at least as tall, then push this column
   localparam logic [1:0] ST_FLUSH = 2'd2;  // row end, drain the stack
   localparam logic [1:0] ST_DONE  = 2'd3;  // grid end, hand off the area

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [COL_W-1:0]  colpos_ff, colpos_in;
   logic [COL_W-1:0]  pos_ff, pos_in;
   logic              cell_ff, cell_in;
   logic              last_ff, last_in;
   logic              row_end_ff, row_end_in;
   logic              first_ff, first_in;
   logic [HGT_W-1:0]  h_ff, h_in;
   logic [COL_W-1:0]  left_ff, left_in;
   logic [AREA_W-1:0] best_ff, best_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [AREA_W-1:0] rsp_data_ff, rsp_data_in;

   // row length and end-of-row test for the incoming cell
   logic [CNT_W-1:0]  row_len;
   logic [CNT_W-1:0]  pos_plus;
   logic              req_row_end;

   // column height update
   logic [HGT_W-1:0]  h_old, h_new, h_cur;
   logic              ht_rd_en, ht_wr_en, ht_clear;

   // stack control
   stk_cmd_type       cmd;
   stk_view_type      view;
   logic              pop_hit;

   // scoring
   logic              score_en;
   logic [DEPTH_W-1:0] score_w, width_row, width_flush;
   logic [PROD_W-1:0] prod;
   logic [AREA_W-1:0] capped;

   always_comb begin
      if (count_ff == '0) begin
         row_len = CNT_W'(1);
      end else if (count_ff > CNT_W'(MAX_COLUMNS)) begin
         row_len = CNT_W'(MAX_COLUMNS);
      end else begin
         row_len = count_ff;
      end
   end

   assign pos_plus    = CNT_W'(colpos_ff) + CNT_W'(1);
   assign req_row_end = req_tlast || (pos_plus >= row_len);

   // 0 clears the column, 1 grows it up to the row limit
   assign h_new = !cell_ff ? '0 :
                  (h_old < HGT_W'(MAX_ROWS)) ? h_old + HGT_W'(1) : h_old;
   assign h_cur = first_ff ? h_new : h_ff;

   assign pop_hit = view.nonempty && (view.top.height >= h_cur);

   // bar spans from its left edge up to this column (exclusive) or past it
   assign width_row   = DEPTH_W'(pos_ff) - DEPTH_W'(view.top.left);
   assign width_flush = DEPTH_W'(pos_ff) + DEPTH_W'(1) - DEPTH_W'(view.top.left);
   assign score_w     = (state_ff == ST_FLUSH) ? width_flush : width_row;

   assign prod   = PROD_W'(view.top.height) * PROD_W'(score_w);
   assign capped = (prod > PROD_W'(AREA_CAP)) ? AREA_CAP : prod[AREA_W-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = csr_wr_en ? csr_wr_data : count_ff;
      colpos_in    = colpos_ff;
      pos_in       = pos_ff;
      cell_in      = cell_ff;
      last_in      = last_ff;
      row_end_in   = row_end_ff;
      first_in     = first_ff;
      h_in         = h_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      cmd          = '0;
      ht_rd_en     = 1'b0;
      ht_wr_en     = 1'b0;
      ht_clear     = 1'b0;
      score_en     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               pos_in     = colpos_ff;
               cell_in    = req_tdata[0];
               last_in    = req_tlast;
               row_end_in = req_row_end;
               colpos_in  = req_row_end ? '0 : pos_plus[COL_W-1:0];
               left_in    = colpos_ff;
               first_in   = 1'b1;
               ht_rd_en   = 1'b1;
               state_in   = ST_PROC;
            end
         end
         ST_PROC: begin
            first_in = 1'b0;
            if (first_ff) begin
               ht_wr_en = 1'b1;
               h_in     = h_new;
            end
            if (pop_hit) begin
               cmd.pop  = 1'b1;
               score_en = 1'b1;
               // the pushed bar will reach back to the last popped edge
               left_in  = view.top.left;
            end else begin
               cmd.push         = 1'b1;
               cmd.entry.height = h_cur;
               cmd.entry.left   = left_ff;
               state_in         = row_end_ff ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (view.nonempty) begin
               cmd.pop  = 1'b1;
               score_en = 1'b1;
            end else begin
               state_in = last_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_DONE: begin
            // wait for the output register, then start a fresh grid
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = best_ff;
               cmd.clear    = 1'b1;
               ht_clear     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (state_ff == ST_DONE && state_in == ST_IDLE) begin
         best_in = '0;
      end else if (score_en && (capped > best_ff)) begin
         best_in = capped;
      end else begin
         best_in = best_ff;
      end
   end

   mrbg_height_ram u_heights (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (ht_rd_en),
      .rd_addr (colpos_ff),
      .rd_data (h_old),
      .wr_en   (ht_wr_en),
      .wr_addr (pos_ff),
      .wr_data (h_new),
      .clear   (ht_clear)
   );

   mrbg_stack u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .view  (view)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= COLUMN_COUNT_RESET;
         colpos_ff    <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         colpos_ff    <= colpos_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
      end
   end

   // per-cell payload
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      cell_ff     <= cell_in;
      last_ff     <= last_in;
      row_end_ff  <= row_end_in;
      h_ff        <= h_in;
      left_ff     <= left_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - AREA_W){1'b0}}, rsp_data_ff};

endmodule

// File: sv/mrbg_height_ram.sv
// ----------------------------------------------------------------------------
// mrbg_height_ram
// column height memory, registered read, valid bits to clear all entries at once
// ----------------------------------------------------------------------------
module mrbg_height_ram (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [mrbg_pkg::COL_W-1:0]  rd_addr,
   output logic [mrbg_pkg::HGT_W-1:0]  rd_data,
   input  logic                        wr_en,
   input  logic [mrbg_pkg::COL_W-1:0]  wr_addr,
   input  logic [mrbg_pkg::HGT_W-1:0]  wr_data,
   input  logic                        clear
);
   import mrbg_pkg::*;

   logic [HGT_W-1:0]       mem [MAX_COLUMNS];
   logic [MAX_COLUMNS-1:0] valid_ff;
   logic [HGT_W-1:0]       rd_data_ff;
   logic                   rd_vld_ff;

   // entries never written since the last clear read as zero
   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

endmodule

// File: sv/mrbg_stack.sv
// ----------------------------------------------------------------------------
// mrbg_stack
// monotonic bar stack: top entry in registers, the rest in a synchronous memory
// ----------------------------------------------------------------------------
module mrbg_stack (
   input  logic                  clock,
   input  logic                  reset,
   input  mrbg_pkg::stk_cmd_type  cmd,
   output mrbg_pkg::stk_view_type view
);
   import mrbg_pkg::*;

   stk_entry_type      mem [MAX_COLUMNS];
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   stk_entry_type      top_ff, top_in;
   stk_entry_type      rd_data_ff, fwd_data_ff, below;
   logic               fwd_ff;
   logic               wr_en;
   logic [DEPTH_W-1:0] rd_full, wr_full;
   logic [COL_W-1:0]   rd_addr, wr_addr;

   // entry just under the top; a push writes the address being read, so forward
   assign below = fwd_ff ? fwd_data_ff : rd_data_ff;

   always_comb begin
      depth_in = depth_ff;
      top_in   = top_ff;
      wr_en    = 1'b0;
      if (cmd.clear) begin
         depth_in = '0;
      end else if (cmd.pop) begin
         depth_in = depth_ff - DEPTH_W'(1);
         top_in   = below;
      end else if (cmd.push) begin
         wr_en    = (depth_ff != '0);
         top_in   = cmd.entry;
         depth_in = depth_ff + DEPTH_W'(1);
      end
   end

   // keep the read aimed at the slot under the next top
   assign rd_full = depth_in - DEPTH_W'(2);
   assign wr_full = depth_ff - DEPTH_W'(1);
   assign rd_addr = rd_full[COL_W-1:0];
   assign wr_addr = wr_full[COL_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= top_ff;
      end
      rd_data_ff  <= mem[rd_addr];
      fwd_data_ff <= top_ff;
      top_ff      <= top_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         fwd_ff   <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         fwd_ff   <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign view.nonempty = (depth_ff != '0);
   assign view.top      = top_ff;

endmodule

// File: sv/mrbg_checker.sv
// ----------------------------------------------------------------------------
// mrbg_checker
// port-level checks for the rectangle block, bound to the top level
// ----------------------------------------------------------------------------
module mrbg_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mrbg_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import mrbg_pkg::*;

   // a stalled result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a request is never taken in the cycle right after another is taken
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken on back-to-back cycles");

   // area never exceeds the full grid and padding stays zero
   a_area_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= RSP_DATA_W'(MAX_COLUMNS * MAX_ROWS))
      else $error("result area out of range");

   // reset leaves the block ready with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

endmodule

bind maximal_rectangle_binary_grid mrbg_checker u_mrbg_checker (.*);

// File: dv/rect_area_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rect_area_pkg
// running histogram tracker that predicts the largest all-ones rectangle
// ----------------------------------------------------------------------------
package rect_area_pkg;
   import mrbg_pkg::*;

   class rect_area_tracker;
      bit [HGT_W-1:0]  col_height [MAX_COLUMNS];
      bit [COL_W-1:0]  col_stack [MAX_COLUMNS];
      int unsigned     stack_fill;
      int unsigned     col_pos;
      bit [AREA_W-1:0] best;
      bit [CNT_W-1:0]  col_count;
      bit [AREA_W-1:0] area_queue [$];
      int unsigned     mismatches;

      function new();
         col_count  = COLUMN_COUNT_RESET;
         mismatches = 0;
         clear_grid();
      endfunction

      function void clear_grid();
         foreach (col_height[i]) col_height[i] = '0;
         stack_fill = 0;
         col_pos    = 0;
         best       = '0;
      endfunction

      function void set_columns(bit [CNT_W-1:0] value);
         col_count = value;
      endfunction

      function int unsigned row_len();
         if (col_count == 0) return 1;
         if (col_count > MAX_COLUMNS) return MAX_COLUMNS;
         return col_count;
      endfunction

      // pop the top bar and score it against the right boundary
      function void pop_scored(int unsigned right_col);
         int unsigned top;
         int unsigned width;
         int unsigned area;
         stack_fill--;
         top = col_stack[stack_fill];
         if (stack_fill == 0) width = right_col;
         else width = right_col - col_stack[stack_fill-1] - 1;
         area = int'(col_height[top]) * width;
         if (area > AREA_CAP) area = AREA_CAP;
         if (area > best) best = AREA_W'(area);
      endfunction

      function void note_cell(bit cell_bit, bit last_bit);
         int unsigned    n;
         int unsigned    p;
         bit [HGT_W-1:0] h;
         n = row_len();
         p = col_pos;
         if (p >= MAX_COLUMNS) p = MAX_COLUMNS - 1;
         if (!cell_bit) col_height[p] = '0;
         else if (col_height[p] < MAX_ROWS) col_height[p]++;
         h = col_height[p];
         while (stack_fill > 0 && col_height[col_stack[stack_fill-1]] >= h)
            pop_scored(p);
         if (stack_fill < MAX_COLUMNS) begin
            col_stack[stack_fill] = COL_W'(p);
            stack_fill++;
         end
         if (last_bit || p + 1 >= n) begin
            while (stack_fill > 0) pop_scored(p + 1);
            col_pos = 0;
         end else begin
            col_pos = p + 1;
         end
         if (last_bit) begin
            area_queue.push_back(best);
            clear_grid();
         end
      endfunction

      function void check_area(logic [RSP_DATA_W-1:0] data);
         bit [AREA_W-1:0] want;
         if (area_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result, area %0d", $time, data[AREA_W-1:0]);
            return;
         end
         want = area_queue.pop_front();
         if (data[AREA_W-1:0] !== want || data[RSP_DATA_W-1:AREA_W] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: area mismatch, expected %0d got %0d (pad %h)", $time,
                        want, data[AREA_W-1:0], data[RSP_DATA_W-1:AREA_W]);
         end
      endfunction

      function int unsigned pending();
         return area_queue.size();
      endfunction
   endclass

endpackage

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// streams binary grids into the rectangle block and checks every grid area
// ----------------------------------------------------------------------------
// A short directed run covers single-cell grids, one-column and clamped row
// lengths and a row length lowered in the middle of a row. Random grids follow
// in four handshake phases (no idling, sender gaps, receiver stalls, both),
// with the row length rewritten while the block is idle, between grids and
// inside cut-row grids; the tracker in rect_area_pkg predicts each grid's area.
// ----------------------------------------------------------------------------
module tb_top;
   import mrbg_pkg::*;
   import rect_area_pkg::*;

   localparam int SETTLE_CYCLES = 2 * MAX_COLUMNS + 16;  // worst row flush plus margin
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_CELLS   = 475;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en;
   logic [CNT_W-1:0]      csr_wr_data;

   rect_area_tracker area_sb;
   int unsigned      idle_pct;
   int unsigned      stall_pct;
   int unsigned      cells_sent;
   int unsigned      cur_count;
   int unsigned      cycle_count;

   maximal_rectangle_binary_grid dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver stalls at random, per phase
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) area_sb.note_cell(req_tdata[0], req_tlast);
         if (rsp_tvalid && rsp_tready) area_sb.check_area(rsp_tdata);
      end
   end

   // row length as the block sees it
   function automatic int unsigned eff_len(int unsigned value);
      if (value == 0) return 1;
      if (value > MAX_COLUMNS) return MAX_COLUMNS;
      return value;
   endfunction

   // mostly short rows, now and then a zero or a clamped count
   function automatic int unsigned pick_count();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5) return 0;
      if (r < 10) return $urandom_range(256, 511);
      if (r < 25) return $urandom_range(11, 40);
      return $urandom_range(1, 10);
   endfunction

   // one cell request, with a random gap in front of it
   task automatic send_cell(input bit cell_bit, input bit last_bit);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(cell_bit);
      req_tlast  <= last_bit;
      do @(posedge clock); while (!req_tready);
      cells_sent++;
      @(negedge clock);
   endtask

   // hold off until every area is back and any row flush has finished
   task automatic drain_idle();
      req_tvalid <= 1'b0;
      while (area_sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // only called while idle, so no request shares the write edge
   task automatic write_columns(input int unsigned value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CNT_W'(value);
      @(posedge clock);
      area_sb.set_columns(CNT_W'(value));
      cur_count = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // whole grid of random density, sometimes ending mid-row
   task automatic random_grid();
      int unsigned n;
      int unsigned rows;
      int unsigned dens;
      int unsigned total;
      n    = eff_len(cur_count);
      rows = (n > 40) ? $urandom_range(1, 2) : $urandom_range(1, 6);
      case ($urandom_range(0, 5))
         0: dens = 0;
         1: dens = 40;
         2: dens = 50;
         3: dens = 75;
         4: dens = 90;
         default: dens = 100;
      endcase
      total = rows * n;
      if ($urandom_range(99) < 15) total = (rows - 1) * n + $urandom_range(1, n);
      for (int unsigned k = 0; k < total; k++)
         send_cell($urandom_range(99) < dens, k == total - 1);
   endtask

   // partial row, then a shorter row length that ends the row at the next cell
   task automatic cut_row_grid();
      int unsigned j;
      int unsigned tail;
      drain_idle();
      if (eff_len(cur_count) < 2) write_columns($urandom_range(2, 12));
      j = $urandom_range(1, eff_len(cur_count) - 1);
      for (int unsigned k = 0; k < j; k++) send_cell($urandom_range(99) < 80, 1'b0);
      drain_idle();
      write_columns($urandom_range(0, j));
      tail = $urandom_range(1, 3 * eff_len(cur_count));
      for (int unsigned k = 0; k < tail; k++)
         send_cell($urandom_range(99) < 80, k == tail - 1);
   endtask

   initial begin
      int unsigned phase_goal;
      area_sb     = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      idle_pct    = 0;
      stall_pct   = 0;
      cells_sent  = 0;
      cycle_count = 0;
      cur_count   = COLUMN_COUNT_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single-cell grids, last cell mid-row at the reset row length
      send_cell(1'b1, 1'b1);
      send_cell(1'b0, 1'b1);

      // 2x3 grid with a 2x2 block of ones
      drain_idle();
      write_columns(3);
      send_cell(1'b1, 1'b0); send_cell(1'b1, 1'b0); send_cell(1'b0, 1'b0);
      send_cell(1'b1, 1'b0); send_cell(1'b1, 1'b0); send_cell(1'b1, 1'b1);

      // zero count means one column per row
      drain_idle();
      write_columns(0);
      send_cell(1'b1, 1'b0); send_cell(1'b1, 1'b0);
      send_cell(1'b0, 1'b0); send_cell(1'b1, 1'b1);

      // all count bits set, clamps to the widest row
      drain_idle();
      write_columns(511);
      send_cell(1'b0, 1'b0); send_cell(1'b1, 1'b0); send_cell(1'b1, 1'b1);

      // count lowered below the current position in the middle of a row
      drain_idle();
      write_columns(6);
      repeat (4) send_cell(1'b1, 1'b0);
      drain_idle();
      write_columns(2);
      send_cell(1'b1, 1'b0); send_cell(1'b1, 1'b0);
      send_cell(1'b1, 1'b0); send_cell(1'b0, 1'b1);

      for (int ph = 0; ph < 4; ph++) begin
         drain_idle();
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 50; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 50; end
            default: begin idle_pct = 24; stall_pct = 24; end
         endcase
         phase_goal = cells_sent + PHASE_CELLS;

         // one tall column of ones, height saturates
         if (ph == 0) begin
            write_columns(1);
            repeat (299) send_cell(1'b1, 1'b0);
            send_cell(1'b1, 1'b1);
         end

         while (cells_sent < phase_goal) begin
            if ($urandom_range(99) < 20) begin
               drain_idle();
               write_columns(pick_count());
            end
            if ($urandom_range(99) < 6) cut_row_grid();
            else random_grid();
         end
      end

      // all requests in, wait out the results and the last flush
      req_tvalid <= 1'b0;
      while (area_sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (area_sb.mismatches == 0 && area_sb.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
